@@ design/utd_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

  // Masks for the payload bits of continuation and lead bytes.
  localparam logic [7:0]  ContMask  = 8'h3f;
  localparam logic [7:0]  Lead2Mask = 8'h1f;
  localparam logic [15:0] CodeMask  = 16'hffff;

  // Sequence state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]  bytes_remaining;
    logic [15:0] partial_value;
  } seq_state_t;

  // One decoded result item.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        malformed;
    logic        last_result;
  } result_t;

endpackage

@@ design/utd_decode.sv @@
// ----------------------------------------------------------------------------
// UTF-8 byte decode step
// Combines one registered byte with the sequence state and gives the next
// state and, where the byte completes or breaks a sequence, one result item.
// ----------------------------------------------------------------------------
module utd_decode (
  input  logic [7:0]          byte_i,
  input  logic                eot_i,
  input  utd_pkg::seq_state_t state_i,
  output utd_pkg::seq_state_t state_o,
  output logic                has_result_o,
  output utd_pkg::result_t    result_o
);

  logic [15:0] shifted;
  logic [1:0]  rem_dec;
  logic        bad;
  logic [15:0] code;

  // Continuation byte shifts six payload bits into the partial value.
  assign shifted = {state_i.partial_value[9:0], byte_i[5:0] & utd_pkg::ContMask[5:0]};
  assign rem_dec = state_i.bytes_remaining - 2'd1;

  // Byte classification and sequence update.
  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    bad          = 1'b0;
    code         = 16'h0000;
    if (state_i.bytes_remaining != 2'd0) begin
      if (rem_dec == 2'd0) begin
        has_result_o = 1'b1;
        code         = shifted;
        state_o      = '0;
      end else if (eot_i) begin
        has_result_o = 1'b1;
        bad          = 1'b1;
        state_o      = '0;
      end else begin
        state_o.bytes_remaining = rem_dec;
        state_o.partial_value   = shifted;
      end
    end else begin
      if (!byte_i[7]) begin
        // Plain ASCII byte.
        has_result_o = 1'b1;
        code         = {8'h00, byte_i};
      end else if (!byte_i[6] || (byte_i[5:3] == 3'b111)) begin
        // Stray continuation byte, or a lead with five or more ones.
        has_result_o = 1'b1;
        bad          = 1'b1;
      end else if (eot_i) begin
        // Valid lead byte, but the text ends here.
        has_result_o = 1'b1;
        bad          = 1'b1;
      end else if (!byte_i[5]) begin
        state_o.bytes_remaining = 2'd1;
        state_o.partial_value   = {8'h00, byte_i & utd_pkg::Lead2Mask};
      end else if (!byte_i[4]) begin
        state_o.bytes_remaining = 2'd2;
        state_o.partial_value   = {8'h00, byte_i & (utd_pkg::Lead2Mask >> 1)};
      end else begin
        state_o.bytes_remaining = 2'd3;
        state_o.partial_value   = {8'h00, byte_i & (utd_pkg::Lead2Mask >> 2)};
      end
    end
  end

  // A malformed result always carries a zero code unit.
  assign result_o.code_unit   = bad ? 16'h0000 : (code & utd_pkg::CodeMask);
  assign result_o.malformed   = bad;
  assign result_o.last_result = eot_i;

endmodule

@@ design/utf8_to_ucs2_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder unit
// Streams UTF-8 bytes in and 16-bit code units out, one byte per clock while the output keeps up.
// ----------------------------------------------------------------------------
// Each byte is taken into an input register, decoded in a single pass
// against the sequence state and written to an output register, so one byte
// is accepted every clock while the output side keeps up. A result is offered
// from the output register once its byte has left the input register. Only
// a held-off output stalls the input: while the output register holds an
// item that is not taken, a byte that gives a result waits in the input
// register and no new byte is accepted. Bytes in the middle of a sequence
// give no result. A malformed result (stray continuation byte, lead byte
// with five or more ones, or a sequence cut short by tlast) has a zero
// code unit and tuser set. Output tlast follows the input tlast of the byte
// that caused the result.
module utf8_to_ucs2_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] input_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tuser,   // [0] malformed
  output logic        m_axis_tlast    // last_result
);

  logic                in_valid_q;
  logic [7:0]          in_byte_q;
  logic                in_eot_q;
  utd_pkg::seq_state_t state_q, state_d;
  logic                has_result;
  utd_pkg::result_t    result;
  logic                out_valid_q;
  utd_pkg::result_t    out_q;
  logic                out_free;
  logic                advance;

  utd_decode u_decode (
    .byte_i      (in_byte_q),
    .eot_i       (in_eot_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .has_result_o(has_result),
    .result_o    (result)
  );

  // The input stage moves on unless its result cannot be placed.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!has_result || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
  end

  // Sequence state, updated once per decoded byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.code_unit;
  assign m_axis_tuser  = out_q.malformed;
  assign m_axis_tlast  = out_q.last_result;

  // Malformed results carry a zero code unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.malformed) |-> (out_q.code_unit == 16'h0000))
    else $error("malformed result with non-zero code unit");

  // Between sequences no partial value is kept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bytes_remaining == 2'd0) |-> (state_q.partial_value == 16'h0000))
    else $error("partial value left over while idle");

  // A waiting result is not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost or changed");

endmodule
